### rtl/i2cm_pkg.sv
// shared types and codes of the i2c bus master
// no dependencies

package i2cm_pkg;

	localparam int unsigned HalfPhaseWidth = 16;
	localparam int unsigned PollWidth      = 8;
	localparam int unsigned CfgIndexWidth  = 1;
	localparam int unsigned CfgDataWidth   = HalfPhaseWidth;

	localparam logic [HalfPhaseWidth-1:0] HalfPhaseReset = 16'd150;
	localparam logic [PollWidth-1:0]      AckLimitReset  = 8'd250;

	typedef enum logic [3:0] {
		CMD_START     = 4'd0,
		CMD_STOP      = 4'd1,
		CMD_WRITE     = 4'd2,
		CMD_WAIT_ACK  = 4'd3,
		CMD_READ      = 4'd4,
		CMD_ACK       = 4'd5,
		CMD_NACK      = 4'd6,
		CMD_WRITE_ACK = 4'd7,
		CMD_PROBE     = 4'd8
	} cmd_code_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_HALF_PHASE = 1'b0,
		REG_ACK_LIMIT  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic       command_valid;
		logic [3:0] command;
		logic [7:0] data_byte;
		logic       sda_in;
		logic       scl_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_fail;
	} res_item_t;

endpackage

### rtl/i2cm_cmd_if.sv
// command channel: one tick of the sequencer with sampled line levels
// depends on nothing

interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic       command_valid;
	logic [3:0] command;
	logic [7:0] data_byte;
	logic       sda_in;
	logic       scl_in;

	modport source (output valid, command_valid, command, data_byte, sda_in, scl_in,
		input ready);
	modport sink (input valid, command_valid, command, data_byte, sda_in, scl_in,
		output ready);
endinterface

### rtl/i2cm_res_if.sv
// result channel: driven line levels and command status per tick
// depends on nothing

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_fail;

	modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res,
		read_data, ack_fail, input ready);
	modport sink (input valid, scl_out, sda_out, sda_drive, busy_res, done_res,
		read_data, ack_fail, output ready);
endinterface

### rtl/i2cm_seq.sv
// bus phase sequencer: state registers, config registers and one-tick step logic
// depends on i2cm_pkg

module i2cm_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step_en,
	input  i2cm_pkg::cmd_item_t                 item,
	input  logic                                cfg_we,
	input  logic [i2cm_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [i2cm_pkg::CfgDataWidth-1:0]   cfg_data,
	output i2cm_pkg::res_item_t                 res
);
	import i2cm_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2, PH_WSET, PH_WHIGH, PH_WLOW,
		PH_AREL, PH_AHIGH, PH_APOLL, PH_ALOW, PH_RREL, PH_RHIGH, PH_RSAMP, PH_RLOW,
		PH_K1, PH_K2, PH_K3
	} phase_t;

	phase_t                    phase_q, n_phase, tgt;
	cmd_code_t                 cmd_q, n_cmd;
	logic [3:0]                bit_q, n_bit, bit_inc;
	logic [7:0]                shift_q, n_shift;
	logic [HalfPhaseWidth-1:0] delay_q, n_delay, delay_dec, delay_load;
	logic [PollWidth-1:0]      poll_q, n_poll;
	logic                      scl_q, sda_q, drv_q, n_scl, n_sda, n_drv;
	logic [7:0]                last_read_q, n_last_read;
	logic                      last_ack_q, n_last_ack;
	logic                      go, fin;
	logic [HalfPhaseWidth-1:0] half_phase_q;
	logic [PollWidth-1:0]      ack_limit_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_phase_q <= HalfPhaseReset;
			ack_limit_q  <= AckLimitReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HALF_PHASE: half_phase_q <= cfg_data;
				REG_ACK_LIMIT:  ack_limit_q  <= cfg_data[PollWidth-1:0];
				default: ;
			endcase
		end
	end

	assign delay_load = (half_phase_q == '0) ? HalfPhaseWidth'(1) : half_phase_q;
	assign delay_dec  = (delay_q != '0) ? delay_q - HalfPhaseWidth'(1) : '0;
	assign bit_inc    = bit_q + 4'd1;

	always_comb begin
		n_phase     = phase_q;
		n_cmd       = cmd_q;
		n_bit       = bit_q;
		n_shift     = shift_q;
		n_delay     = delay_q;
		n_poll      = poll_q;
		n_scl       = scl_q;
		n_sda       = sda_q;
		n_drv       = drv_q;
		n_last_read = last_read_q;
		n_last_ack  = last_ack_q;
		go          = 1'b0;
		fin         = 1'b0;
		tgt         = PH_IDLE;

		if (phase_q == PH_IDLE) begin
			if (item.command_valid) begin
				case (cmd_code_t'(item.command))
					CMD_START, CMD_STOP, CMD_WRITE, CMD_WAIT_ACK, CMD_READ, CMD_ACK, CMD_NACK,
					CMD_WRITE_ACK, CMD_PROBE: begin
						n_cmd   = cmd_code_t'(item.command);
						n_bit   = '0;
						n_shift = item.data_byte;
					end
					default: ;
				endcase
				case (cmd_code_t'(item.command))
					CMD_START: begin
						go  = 1'b1;
						tgt = PH_ST1;
					end
					CMD_STOP: begin
						go  = 1'b1;
						tgt = PH_SP1;
					end
					CMD_WRITE, CMD_WRITE_ACK: begin
						go  = 1'b1;
						tgt = PH_WSET;
					end
					CMD_WAIT_ACK: begin
						go  = 1'b1;
						tgt = PH_AREL;
					end
					CMD_READ: begin
						n_shift = '0;
						go      = 1'b1;
						tgt     = PH_RREL;
					end
					CMD_ACK, CMD_NACK: begin
						go  = 1'b1;
						tgt = PH_K1;
					end
					CMD_PROBE: begin
						if (item.scl_in && item.sda_in) begin
							n_shift = {item.data_byte[7:1], 1'b0};
							go      = 1'b1;
							tgt     = PH_ST1;
						end else begin
							n_last_ack = 1'b1;
							fin        = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end else if (phase_q == PH_APOLL) begin
			if (!item.sda_in) begin
				n_last_ack = 1'b0;
				go         = 1'b1;
				tgt        = PH_ALOW;
			end else if (poll_q >= ack_limit_q) begin
				n_last_ack = 1'b1;
				if (cmd_q == CMD_PROBE) begin
					go  = 1'b1;
					tgt = PH_SP1;
				end else begin
					fin = 1'b1;
				end
			end else begin
				n_poll = poll_q + PollWidth'(1);
			end
		end else begin
			n_delay = delay_dec;
			if (delay_dec == '0) begin
				case (phase_q)
					PH_ST1: begin
						go  = 1'b1;
						tgt = PH_ST2;
					end
					PH_ST2: begin
						go  = 1'b1;
						tgt = PH_ST3;
					end
					PH_ST3: begin
						if (cmd_q == CMD_PROBE) begin
							n_bit = '0;
							go    = 1'b1;
							tgt   = PH_WSET;
						end else begin
							fin = 1'b1;
						end
					end
					PH_SP1: begin
						go  = 1'b1;
						tgt = PH_SP2;
					end
					PH_WSET: begin
						go  = 1'b1;
						tgt = PH_WHIGH;
					end
					PH_WHIGH: begin
						go  = 1'b1;
						tgt = PH_WLOW;
					end
					PH_WLOW: begin
						n_bit = bit_inc;
						if (bit_inc < 4'd8) begin
							go  = 1'b1;
							tgt = PH_WSET;
						end else if (cmd_q == CMD_WRITE_ACK || cmd_q == CMD_PROBE) begin
							go  = 1'b1;
							tgt = PH_AREL;
						end else begin
							fin = 1'b1;
						end
					end
					PH_AREL: begin
						go  = 1'b1;
						tgt = PH_AHIGH;
					end
					PH_AHIGH: begin
						go  = 1'b1;
						tgt = PH_APOLL;
					end
					PH_ALOW: begin
						if (cmd_q == CMD_PROBE) begin
							go  = 1'b1;
							tgt = PH_SP1;
						end else begin
							fin = 1'b1;
						end
					end
					PH_RREL: begin
						go  = 1'b1;
						tgt = PH_RHIGH;
					end
					PH_RHIGH: begin
						n_shift = {shift_q[6:0], item.sda_in};
						go      = 1'b1;
						tgt     = PH_RSAMP;
					end
					PH_RSAMP: begin
						go  = 1'b1;
						tgt = PH_RLOW;
					end
					PH_RLOW: begin
						n_bit = bit_inc;
						if (bit_inc < 4'd8) begin
							go  = 1'b1;
							tgt = PH_RHIGH;
						end else begin
							n_last_read = shift_q;
							fin         = 1'b1;
						end
					end
					PH_K1: begin
						go  = 1'b1;
						tgt = PH_K2;
					end
					PH_K2: begin
						go  = 1'b1;
						tgt = PH_K3;
					end
					PH_K3: begin
						if (cmd_q == CMD_ACK) begin
							n_sda = 1'b1;
						end
						fin = 1'b1;
					end
					default: fin = 1'b1;
				endcase
			end
		end

		if (fin) begin
			n_phase = PH_IDLE;
			n_delay = '0;
		end

		// entry actions of the new phase
		if (go) begin
			n_phase = tgt;
			n_delay = delay_load;
			case (tgt)
				PH_ST1: begin
					n_drv = 1'b1;
					n_scl = 1'b1;
					n_sda = 1'b1;
				end
				PH_ST2: n_sda = 1'b0;
				PH_ST3: n_scl = 1'b0;
				PH_SP1: begin
					n_drv = 1'b1;
					n_scl = 1'b0;
					n_sda = 1'b0;
				end
				PH_SP2: begin
					n_scl = 1'b1;
					n_sda = 1'b1;
				end
				PH_WSET: begin
					n_drv = 1'b1;
					n_sda = n_shift[7];
				end
				PH_WHIGH: n_scl = 1'b1;
				PH_WLOW: begin
					n_scl   = 1'b0;
					n_shift = {n_shift[6:0], 1'b0};
				end
				PH_AREL: begin
					n_drv = 1'b0;
					n_sda = 1'b1;
				end
				PH_AHIGH: n_scl = 1'b1;
				PH_APOLL: begin
					n_poll  = '0;
					n_delay = '0;
				end
				PH_ALOW: n_scl = 1'b0;
				PH_RREL: n_sda = 1'b1;
				PH_RHIGH: begin
					n_drv = 1'b0;
					n_scl = 1'b1;
				end
				PH_RLOW: n_scl = 1'b0;
				PH_K1: begin
					n_drv = 1'b1;
					n_sda = (n_cmd == CMD_NACK);
				end
				PH_K2: n_scl = 1'b1;
				PH_K3: n_scl = 1'b0;
				default: ;
			endcase
		end

		res.scl_out   = n_scl;
		res.sda_out   = n_sda;
		res.sda_drive = n_drv;
		res.busy_res  = (n_phase != PH_IDLE);
		res.done_res  = fin;
		res.read_data = n_last_read;
		res.ack_fail  = n_last_ack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cmd_q       <= CMD_START;
			bit_q       <= '0;
			shift_q     <= '0;
			delay_q     <= '0;
			poll_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			drv_q       <= 1'b0;
			last_read_q <= '0;
			last_ack_q  <= 1'b0;
		end else if (step_en) begin
			phase_q     <= n_phase;
			cmd_q       <= n_cmd;
			bit_q       <= n_bit;
			shift_q     <= n_shift;
			delay_q     <= n_delay;
			poll_q      <= n_poll;
			scl_q       <= n_scl;
			sda_q       <= n_sda;
			drv_q       <= n_drv;
			last_read_q <= n_last_read;
			last_ack_q  <= n_last_ack;
		end
	end

endmodule

### rtl/i2c_bus_master.sv
// i2c bus master top level: input stage, sequencer and result register
// depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if, i2cm_seq
//
// usage:
//   cmd_ch carries one sequencer tick per transfer: an optional command
//   (command_valid, command, data_byte) and the sampled sda_in / scl_in.
//   res_ch returns exactly one result per tick, in order: the driven scl/sda
//   levels, sda_drive, busy/done and the last read byte and ack failure.
//   commands offered while busy, and codes above probe, are ignored.
//   path: a tick passes the input stage register, then the result register,
//   before its result can transfer on res_ch.
//   throughput: one tick per cycle unless res_ch stalls; the sequencer step
//   for a tick is one pass of logic between the input stage and the result
//   register. bus timing is counted in ticks: each line change is held for
//   half_phase_ticks ticks (1 if 0); ack polling takes up to ack_poll_limit + 1.
//   config: cfg_we / cfg_index / cfg_data write half_phase_ticks (index 0)
//   and ack_poll_limit (index 1); write only while no command is active.
//   reset: lines released high, not driving sda, sequencer idle, both
//   registers back to 150 and 250, both channels empty.
//   stall: while res_ch.ready is low the result holds, the sequencer stops,
//   and cmd_ch takes at most one more tick, into an empty input stage.

module i2c_bus_master (
	input  logic                                clk,
	input  logic                                arst_n,
	i2cm_cmd_if.sink                            cmd_ch,
	i2cm_res_if.source                          res_ch,
	input  logic                                cfg_we,
	input  logic [i2cm_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [i2cm_pkg::CfgDataWidth-1:0]   cfg_data
);
	import i2cm_pkg::*;

	cmd_item_t item_s1;
	logic      valid_s1;
	res_item_t step_res;
	res_item_t res_q;
	logic      res_valid_q;
	logic      step_en;

	assign step_en      = valid_s1 && (!res_valid_q || res_ch.ready);
	assign cmd_ch.ready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			item_s1.command_valid <= cmd_ch.command_valid;
			item_s1.command       <= cmd_ch.command;
			item_s1.data_byte     <= cmd_ch.data_byte;
			item_s1.sda_in        <= cmd_ch.sda_in;
			item_s1.scl_in        <= cmd_ch.scl_in;
		end
	end

	i2cm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_en) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= step_res;
		end
	end

	assign res_ch.valid     = res_valid_q;
	assign res_ch.scl_out   = res_q.scl_out;
	assign res_ch.sda_out   = res_q.sda_out;
	assign res_ch.sda_drive = res_q.sda_drive;
	assign res_ch.busy_res  = res_q.busy_res;
	assign res_ch.done_res  = res_q.done_res;
	assign res_ch.read_data = res_q.read_data;
	assign res_ch.ack_fail  = res_q.ack_fail;

endmodule

### rtl/i2cm_chk.sv
// port-level checker for the i2c bus master, bound to the top level
// depends on i2c_bus_master ports

module i2cm_chk (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic sda_out,
	input logic sda_drive,
	input logic busy_res,
	input logic done_res
);

	// a completing tick leaves the sequencer idle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done with busy set");

	// sda is released high whenever the master does not drive it
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !sda_drive |-> sda_out)
		else $error("sda low while not driven");

	// stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped during stall");

endmodule

bind i2c_bus_master i2cm_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_ch.valid),
	.res_ready (res_ch.ready),
	.sda_out   (res_ch.sda_out),
	.sda_drive (res_ch.sda_drive),
	.busy_res  (res_ch.busy_res),
	.done_res  (res_ch.done_res)
);

### tb/i2cm_checker.sv
`timescale 1ns / 1ps
// bus tick checker: watches the command and result channels and the register
// write port, predicts every result tick and compares it
// depends on i2cm_pkg, i2cm_cmd_if and i2cm_res_if

module i2cm_checker
	import i2cm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	i2cm_cmd_if                      cmd_mon,
	i2cm_res_if                      res_mon,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	output int unsigned              fail_count,
	output int unsigned              pending,
	output int unsigned              cmds_taken,
	output int unsigned              ticks_checked,
	output logic                     line_busy
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_START_HI, ST_START_SDA, ST_START_SCL, ST_STOP_LO, ST_STOP_HI,
		ST_BIT_SET, ST_BIT_HIGH, ST_BIT_LOW, ST_ACK_REL, ST_ACK_HIGH, ST_ACK_POLL,
		ST_ACK_LOW, ST_RD_REL, ST_RD_HIGH, ST_RD_SAMPLE, ST_RD_LOW, ST_RSP_SET,
		ST_RSP_HIGH, ST_RSP_LOW
	} bus_phase_t;

	logic [HalfPhaseWidth-1:0] half_ticks;
	logic [PollWidth-1:0]      poll_limit;
	bus_phase_t                ph;
	cmd_code_t                 op;
	logic [3:0]                bit_cnt;
	logic [7:0]                shifter;
	logic [HalfPhaseWidth-1:0] delay_left;
	logic [PollWidth-1:0]      polls;
	logic                      scl_q, sda_q, drv_q, ack_q, done_q;
	logic [7:0]                last_byte;

	res_item_t   tick_results[$];
	cmd_item_t   tick_in;
	res_item_t   got, want;
	int unsigned errs, taken_n, checked_n;

	task automatic report_mismatch(input string what, input int unsigned seen,
			input int unsigned wanted);
		errs++;
		if (errs <= 100)
			$display("mismatch at result tick %0d: %s is %0h, predicted %0h",
				checked_n, what, seen, wanted);
	endtask

	function automatic void enter_phase(input bus_phase_t p);
		ph = p;
		delay_left = (half_ticks == '0) ? HalfPhaseWidth'(1) : half_ticks;
		case (p)
			ST_START_HI: begin
				drv_q = 1'b1; scl_q = 1'b1; sda_q = 1'b1;
			end
			ST_START_SDA: sda_q = 1'b0;
			ST_START_SCL: scl_q = 1'b0;
			ST_STOP_LO: begin
				drv_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
			end
			ST_STOP_HI: begin
				scl_q = 1'b1; sda_q = 1'b1;
			end
			ST_BIT_SET: begin
				drv_q = 1'b1; sda_q = shifter[7];
			end
			ST_BIT_HIGH: scl_q = 1'b1;
			ST_BIT_LOW: begin
				scl_q = 1'b0; shifter = {shifter[6:0], 1'b0};
			end
			ST_ACK_REL: begin
				drv_q = 1'b0; sda_q = 1'b1;
			end
			ST_ACK_HIGH: scl_q = 1'b1;
			ST_ACK_POLL: begin
				polls = '0; delay_left = '0;
			end
			ST_ACK_LOW: scl_q = 1'b0;
			ST_RD_REL: sda_q = 1'b1;
			ST_RD_HIGH: begin
				drv_q = 1'b0; scl_q = 1'b1;
			end
			ST_RD_LOW: scl_q = 1'b0;
			ST_RSP_SET: begin
				drv_q = 1'b1; sda_q = (op == CMD_NACK);
			end
			ST_RSP_HIGH: scl_q = 1'b1;
			ST_RSP_LOW: scl_q = 1'b0;
			default: ;
		endcase
	endfunction

	function automatic void end_command();
		ph = ST_IDLE;
		delay_left = '0;
		done_q = 1'b1;
	endfunction

	// a probe still sends stop after its address byte
	function automatic void after_ack();
		if (op == CMD_PROBE) enter_phase(ST_STOP_LO);
		else end_command();
	endfunction

	function automatic void advance_phase(input logic sda);
		case (ph)
			ST_START_HI: enter_phase(ST_START_SDA);
			ST_START_SDA: enter_phase(ST_START_SCL);
			ST_START_SCL: begin
				if (op == CMD_PROBE) begin
					bit_cnt = '0;
					enter_phase(ST_BIT_SET);
				end else begin
					end_command();
				end
			end
			ST_STOP_LO: enter_phase(ST_STOP_HI);
			ST_STOP_HI: end_command();
			ST_BIT_SET: enter_phase(ST_BIT_HIGH);
			ST_BIT_HIGH: enter_phase(ST_BIT_LOW);
			ST_BIT_LOW: begin
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt < 4'd8) enter_phase(ST_BIT_SET);
				else if (op == CMD_WRITE_ACK || op == CMD_PROBE) enter_phase(ST_ACK_REL);
				else end_command();
			end
			ST_ACK_REL: enter_phase(ST_ACK_HIGH);
			ST_ACK_HIGH: enter_phase(ST_ACK_POLL);
			ST_ACK_LOW: after_ack();
			ST_RD_REL: enter_phase(ST_RD_HIGH);
			ST_RD_HIGH: begin
				shifter = {shifter[6:0], sda};
				enter_phase(ST_RD_SAMPLE);
			end
			ST_RD_SAMPLE: enter_phase(ST_RD_LOW);
			ST_RD_LOW: begin
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt < 4'd8) begin
					enter_phase(ST_RD_HIGH);
				end else begin
					last_byte = shifter;
					end_command();
				end
			end
			ST_RSP_SET: enter_phase(ST_RSP_HIGH);
			ST_RSP_HIGH: enter_phase(ST_RSP_LOW);
			ST_RSP_LOW: begin
				if (op == CMD_ACK) sda_q = 1'b1;
				end_command();
			end
			default: end_command();
		endcase
	endfunction

	function automatic res_item_t step_bus(input cmd_item_t t);
		done_q = 1'b0;
		if (ph == ST_IDLE) begin
			if (t.command_valid && t.command <= CMD_PROBE) begin
				op = cmd_code_t'(t.command);
				bit_cnt = '0;
				shifter = t.data_byte;
				taken_n++;
				case (op)
					CMD_START: enter_phase(ST_START_HI);
					CMD_STOP: enter_phase(ST_STOP_LO);
					CMD_WRITE, CMD_WRITE_ACK: enter_phase(ST_BIT_SET);
					CMD_WAIT_ACK: enter_phase(ST_ACK_REL);
					CMD_READ: begin
						shifter = '0;
						enter_phase(ST_RD_REL);
					end
					CMD_ACK, CMD_NACK: enter_phase(ST_RSP_SET);
					default: begin
						// probe on a busy bus ends at once with no response
						if (t.scl_in && t.sda_in) begin
							shifter = {t.data_byte[7:1], 1'b0};
							enter_phase(ST_START_HI);
						end else begin
							ack_q = 1'b1;
							end_command();
						end
					end
				endcase
			end
		end else if (ph == ST_ACK_POLL) begin
			if (!t.sda_in) begin
				ack_q = 1'b0;
				enter_phase(ST_ACK_LOW);
			end else if (polls >= poll_limit) begin
				ack_q = 1'b1;
				after_ack();
			end else begin
				polls = polls + PollWidth'(1);
			end
		end else begin
			if (delay_left != '0) delay_left = delay_left - HalfPhaseWidth'(1);
			if (delay_left == '0) advance_phase(t.sda_in);
		end
		return '{scl_out: scl_q, sda_out: sda_q, sda_drive: drv_q,
			busy_res: (ph != ST_IDLE), done_res: done_q, read_data: last_byte,
			ack_fail: ack_q};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_ticks = HalfPhaseReset;
			poll_limit = AckLimitReset;
			ph = ST_IDLE;
			op = CMD_START;
			bit_cnt = '0;
			shifter = '0;
			delay_left = '0;
			polls = '0;
			scl_q = 1'b1;
			sda_q = 1'b1;
			drv_q = 1'b0;
			ack_q = 1'b0;
			done_q = 1'b0;
			last_byte = '0;
			tick_results.delete();
			errs = 0;
			taken_n = 0;
			checked_n = 0;
			fail_count <= 0;
			pending <= 0;
			cmds_taken <= 0;
			ticks_checked <= 0;
			line_busy <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_HALF_PHASE: half_ticks = cfg_data;
					REG_ACK_LIMIT: poll_limit = cfg_data[PollWidth-1:0];
					default: ;
				endcase
			end
			if (cmd_mon.valid && cmd_mon.ready) begin
				tick_in = '{command_valid: cmd_mon.command_valid, command: cmd_mon.command,
					data_byte: cmd_mon.data_byte, sda_in: cmd_mon.sda_in,
					scl_in: cmd_mon.scl_in};
				tick_results.push_back(step_bus(tick_in));
			end
			if (res_mon.valid && res_mon.ready) begin
				got = '{scl_out: res_mon.scl_out, sda_out: res_mon.sda_out,
					sda_drive: res_mon.sda_drive, busy_res: res_mon.busy_res,
					done_res: res_mon.done_res, read_data: res_mon.read_data,
					ack_fail: res_mon.ack_fail};
				if (tick_results.size() == 0) begin
					report_mismatch("result with no tick waiting", 1, 0);
				end else begin
					want = tick_results.pop_front();
					if (got.scl_out !== want.scl_out)
						report_mismatch("scl_out", got.scl_out, want.scl_out);
					if (got.sda_out !== want.sda_out)
						report_mismatch("sda_out", got.sda_out, want.sda_out);
					if (got.sda_drive !== want.sda_drive)
						report_mismatch("sda_drive", got.sda_drive, want.sda_drive);
					if (got.busy_res !== want.busy_res)
						report_mismatch("busy_res", got.busy_res, want.busy_res);
					if (got.done_res !== want.done_res)
						report_mismatch("done_res", got.done_res, want.done_res);
					if (got.read_data !== want.read_data)
						report_mismatch("read_data", got.read_data, want.read_data);
					if (got.ack_fail !== want.ack_fail)
						report_mismatch("ack_fail", got.ack_fail, want.ack_fail);
					checked_n++;
				end
			end
			fail_count <= errs;
			pending <= tick_results.size();
			cmds_taken <= taken_n;
			ticks_checked <= checked_n;
			line_busy <= (ph != ST_IDLE);
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// top of the i2c bus master testbench: clock, reset, tick stimulus, result
// stalls and register writes
// depends on i2cm_pkg, both channel interfaces, i2c_bus_master and i2cm_checker

module testbench;
	import i2cm_pkg::*;

	localparam int unsigned CycleLimit    = 50_000;
	localparam int unsigned HoldOffAt     = 60;
	localparam int unsigned HoldOffCycles = 80;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [CfgDataWidth-1:0]  cfg_data;
	logic                     quiet;
	int unsigned              fail_count, pending, cmds_taken, ticks_checked;
	logic                     line_busy;
	int unsigned              cycles = 0;
	int unsigned              settings;

	i2cm_cmd_if cmd_ch ();
	i2cm_res_if res_ch ();

	i2c_bus_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.res_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	i2cm_checker bus_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_mon       (cmd_ch),
		.res_mon       (res_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.cmds_taken    (cmds_taken),
		.ticks_checked (ticks_checked),
		.line_busy     (line_busy)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d ticks still expected", cycles, pending);
			$display("testbench failed");
			$finish;
		end
	end

	initial begin : result_sink
		int unsigned taken, hold;
		logic held;
		taken = 0;
		hold = 0;
		held = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) taken++;
			if (!held && taken >= HoldOffAt) begin
				held = 1'b1;
				hold = HoldOffCycles;
			end
			if (hold != 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= quiet || ($urandom_range(0, 99) >= 17);
			end
		end
	end

	task automatic send_tick(input logic cv, input logic [3:0] code, input logic [7:0] value,
			input logic sda, input logic scl);
		while (!quiet && $urandom_range(0, 99) < 17) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command_valid <= cv;
		cmd_ch.command <= code;
		cmd_ch.data_byte <= value;
		cmd_ch.sda_in <= sda;
		cmd_ch.scl_in <= scl;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// busy flag lags one transfer, so the last filler tick is sent after the command ends
	task automatic run_command(input logic [3:0] code, input logic [7:0] value,
			input int unsigned low_pct, input logic scl_now, input logic sda_now,
			input int unsigned stray_pct);
		send_tick(1'b1, code, value, sda_now, scl_now);
		do begin
			send_tick($urandom_range(0, 99) < stray_pct, 4'($urandom_range(0, 15)),
				8'($urandom), $urandom_range(0, 99) >= low_pct, $urandom_range(0, 15) != 0);
		end while (line_busy);
	endtask

	task automatic drain();
		do begin
			send_tick(1'b0, 4'($urandom_range(0, 15)), 8'($urandom), 1'b1, 1'b1);
		end while (line_busy);
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(input logic [CfgDataWidth-1:0] half,
			input logic [CfgDataWidth-1:0] limit);
		cfg_we <= 1'b1;
		cfg_index <= REG_HALF_PHASE;
		cfg_data <= half;
		@(posedge clk);
		cfg_index <= REG_ACK_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin : stimulus
		cmd_ch.valid = 1'b0;
		cmd_ch.command_valid = 1'b0;
		cmd_ch.command = '0;
		cmd_ch.data_byte = '0;
		cmd_ch.sda_in = 1'b1;
		cmd_ch.scl_in = 1'b1;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		settings = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset timing
		run_command(CMD_STOP, 8'h00, 0, 1'b1, 1'b1, 0);
		drain();

		set_config(16'd1, 16'd3);
		run_command(CMD_START, 8'h00, 0, 1'b1, 1'b1, 0);
		run_command(CMD_WRITE, 8'hC3, 50, 1'b1, 1'b1, 0);
		run_command(CMD_WRITE_ACK, 8'hA5, 100, 1'b1, 1'b1, 0);
		run_command(CMD_WRITE_ACK, 8'h5A, 0, 1'b1, 1'b1, 0);
		run_command(CMD_WAIT_ACK, 8'h00, 40, 1'b1, 1'b1, 0);
		run_command(CMD_READ, 8'h00, 50, 1'b1, 1'b1, 0);
		run_command(CMD_ACK, 8'h00, 0, 1'b1, 1'b1, 0);
		run_command(CMD_NACK, 8'h00, 0, 1'b1, 1'b1, 0);
		run_command(CMD_STOP, 8'h00, 0, 1'b1, 1'b1, 0);
		drain();

		// zero half phase counts as one, upper data bits of the limit write are dropped
		quiet <= 1'b1;
		set_config(16'd0, 16'h5A00);
		run_command(CMD_PROBE, 8'hFF, 100, 1'b1, 1'b1, 0);
		run_command(CMD_PROBE, 8'h00, 0, 1'b1, 1'b1, 0);
		run_command(CMD_PROBE, 8'h42, 100, 1'b0, 1'b1, 0);
		run_command(CMD_PROBE, 8'h43, 100, 1'b1, 1'b0, 0);
		run_command(4'd9, 8'h11, 50, 1'b1, 1'b1, 0);
		run_command(4'd15, 8'hEE, 50, 1'b1, 1'b1, 0);
		send_tick(1'b0, CMD_PROBE, 8'hFF, 1'b1, 1'b1);
		run_command(CMD_WRITE, 8'h3C, 50, 1'b1, 1'b1, 60);
		drain();
		quiet <= 1'b0;

		$display("covered %0d bus ticks and %0d commands over %0d timing settings",
			ticks_checked, cmds_taken, settings);
		$display("reset timing, half phase of 1 and 0, ack poll limits of 3 and 0");
		if (fail_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("testbench failed");
		end
		$finish;
	end

endmodule
